>>> rtl/core/dse_pkg.sv
// Shared types and constants of the SDT/EIT section parser.
package dse_pkg;

    localparam logic [1:0] KIND_SDT    = 2'd0;
    localparam logic [1:0] KIND_EIT    = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_OVERRUN   = 3'd2;
    localparam logic [2:0] ST_CRC_FAIL  = 3'd3;
    localparam logic [2:0] ST_WRONG_TBL = 3'd4;

    localparam logic [0:0] REG_SDT_ACTUAL = 1'b0;
    localparam logic [0:0] REG_SDT_OTHER  = 1'b1;

    localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
    localparam logic [12:0] POS_MAX  = 13'd8191;
    localparam int          QDEPTH   = 2;

    // Record handed from the parser to the output queue
    typedef struct packed {
        logic [1:0]  record_kind;
        logic [15:0] entry_id;
        logic        schedule_flag;
        logic        present_following_flag;
        logic [2:0]  run_status;
        logic        free_ca;
        logic [39:0] start_time_raw;
        logic [23:0] duration_raw;
        logic [15:0] ts_id;
        logic [15:0] orig_net_id;
        logic [2:0]  section_status;
    } t_record;

    // One byte of CRC-32/MPEG-2, MSB first
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {b, 24'd0};
        for (int i = 0; i < 8; i++) begin
            c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

>>> rtl/core/dse_front.sv
// Front end: byte tracking, CRC, header capture and entry loop walk.
module dse_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [7:0]        i_section_byte,
    input  logic              i_buffer_end,
    input  logic [7:0]        i_sdt_actual,
    input  logic [7:0]        i_sdt_other,
    output logic              o_emit,
    output dse_pkg::t_record  o_rec
);
    import dse_pkg::*;

    typedef enum logic [3:0] {
        PH_HEADER  = 4'b0001,
        PH_ENTRY   = 4'b0010,
        PH_SKIP    = 4'b0100,
        PH_STOPPED = 4'b1000
    } t_phase;

    logic [12:0] r_pos, n_pos;
    logic [7:0]  r_tid, n_tid;
    logic [11:0] r_slen, n_slen;
    logic [31:0] r_crc, n_crc;
    t_phase      r_ph, n_ph;
    logic [3:0]  r_eidx, n_eidx;
    logic [11:0] r_skip, n_skip;
    logic [63:0] r_f0, n_f0;
    logic [31:0] r_f1, n_f1;
    logic [47:0] r_ids, n_ids;

    logic [13:0] total;
    logic [1:0]  kind, lkind;
    logic [3:0]  hdr;
    logic [12:0] lstart;
    logic [11:0] dll;
    logic [13:0] cnt;
    logic        ent;
    t_record     rec;

    function automatic logic [1:0] kind_of(input logic [7:0] t, input logic [7:0] a,
                                           input logic [7:0] o);
        if (t == a || t == o) return KIND_SDT;
        if (t >= 8'h4E && t <= 8'h6F) return KIND_EIT;
        return KIND_NONE;
    endfunction

    always_comb begin
        n_pos = r_pos; n_tid = r_tid; n_slen = r_slen; n_crc = r_crc; n_ph = r_ph;
        n_eidx = r_eidx; n_skip = r_skip; n_f0 = r_f0; n_f1 = r_f1; n_ids = r_ids;
        ent = 1'b0;
        rec = '0;
        dll = '0;
        total = 14'd3 + {2'b0, r_slen};
        kind = KIND_NONE;
        hdr = 4'd12;
        lstart = 13'd14;
        if (r_pos < 13'd3 || {1'b0, r_pos} < total) begin
            n_crc = crc_byte(r_crc, i_section_byte);
            if (r_pos == 13'd0) n_tid = i_section_byte;
            else if (r_pos == 13'd1) n_slen = {i_section_byte[3:0], 8'd0};
            else if (r_pos == 13'd2) n_slen = {r_slen[11:8], i_section_byte};
            total = 14'd3 + {2'b0, n_slen};
            kind = kind_of(n_tid, i_sdt_actual, i_sdt_other);
            // Header id capture, high byte first
            if (kind == KIND_SDT) begin
                if (r_pos == 13'd3) n_ids[47:40] = i_section_byte;
                if (r_pos == 13'd4) n_ids[39:32] = i_section_byte;
                if (r_pos == 13'd8) n_ids[31:24] = i_section_byte;
                if (r_pos == 13'd9) n_ids[23:16] = i_section_byte;
            end else if (kind == KIND_EIT) begin
                if (r_pos == 13'd3)  n_ids[15:8]  = i_section_byte;
                if (r_pos == 13'd4)  n_ids[7:0]   = i_section_byte;
                if (r_pos == 13'd8)  n_ids[47:40] = i_section_byte;
                if (r_pos == 13'd9)  n_ids[39:32] = i_section_byte;
                if (r_pos == 13'd10) n_ids[31:24] = i_section_byte;
                if (r_pos == 13'd11) n_ids[23:16] = i_section_byte;
            end
            lstart = (kind == KIND_SDT) ? 13'd11 : 13'd14;
            hdr    = (kind == KIND_SDT) ? 4'd5 : 4'd12;
            if (n_ph == PH_HEADER && kind != KIND_NONE && r_pos == lstart) begin
                n_ph = PH_ENTRY;
                n_eidx = '0;
            end
            // Entry loop walk
            if (n_ph == PH_SKIP) begin
                n_skip = r_skip - 12'd1;
                if (n_skip == 12'd0) begin
                    n_ph = PH_ENTRY;
                    n_eidx = '0;
                end
            end else if (n_ph == PH_ENTRY && kind != KIND_NONE) begin
                if (n_eidx == 4'd0 && ({1'b0, r_pos} + {10'd0, hdr} + 14'd4) > total) begin
                    n_ph = PH_STOPPED;
                end else begin
                    if (n_eidx == 4'd0) begin
                        n_f0 = '0;
                        n_f1 = '0;
                    end
                    if (n_eidx < 4'd8) n_f0 = {n_f0[55:0], i_section_byte};
                    else n_f1 = {n_f1[23:0], i_section_byte};
                    n_eidx = n_eidx + 4'd1;
                    if (n_eidx >= hdr) begin
                        if (kind == KIND_SDT) begin
                            dll = {n_f0[11:8], n_f0[7:0]};
                            rec.record_kind = KIND_SDT;
                            rec.entry_id = n_f0[39:24];
                            rec.schedule_flag = n_f0[17];
                            rec.present_following_flag = n_f0[16];
                            rec.run_status = n_f0[15:13];
                            rec.free_ca = n_f0[12];
                        end else begin
                            dll = {n_f1[11:8], n_f1[7:0]};
                            rec.record_kind = KIND_EIT;
                            rec.entry_id = n_f0[63:48];
                            rec.start_time_raw = n_f0[47:8];
                            rec.duration_raw = {n_f0[7:0], n_f1[31:16]};
                        end
                        rec.ts_id = n_ids[47:32];
                        rec.orig_net_id = n_ids[31:16];
                        n_eidx = '0;
                        if (({1'b0, r_pos} + 14'd5 + {2'b0, dll}) > total) begin
                            n_ph = PH_STOPPED;
                        end else begin
                            ent = 1'b1;
                            if (dll != 12'd0) begin
                                n_ph = PH_SKIP;
                                n_skip = dll;
                            end
                        end
                    end
                end
            end
        end
        if (r_pos < POS_MAX) n_pos = r_pos + 13'd1;

        // Status on the last byte of the buffer
        cnt = {1'b0, r_pos} + 14'd1;
        lkind = kind_of(n_tid, i_sdt_actual, i_sdt_other);
        total = 14'd3 + {2'b0, n_slen};
        if (i_buffer_end) begin
            rec = '0;
            rec.record_kind = KIND_STATUS;
            rec.entry_id = (lkind == KIND_EIT) ? n_ids[15:0] : 16'd0;
            rec.present_following_flag = (lkind == KIND_EIT && n_tid <= 8'h4F);
            rec.ts_id = n_ids[47:32];
            rec.orig_net_id = n_ids[31:16];
            if (cnt < 14'd12) rec.section_status = ST_SHORT;
            else if (total > cnt) rec.section_status = ST_OVERRUN;
            else if (n_crc != 32'd0) rec.section_status = ST_CRC_FAIL;
            else if (lkind == KIND_NONE) rec.section_status = ST_WRONG_TBL;
            else rec.section_status = ST_OK;
        end
    end

    assign o_emit = i_take && (i_buffer_end || ent);
    assign o_rec = rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_buffer_end)) begin
            r_pos <= '0; r_tid <= '0; r_slen <= '0; r_crc <= '1; r_ph <= PH_HEADER;
            r_eidx <= '0; r_skip <= '0; r_f0 <= '0; r_f1 <= '0; r_ids <= '0;
        end else if (i_take) begin
            r_pos <= n_pos; r_tid <= n_tid; r_slen <= n_slen; r_crc <= n_crc; r_ph <= n_ph;
            r_eidx <= n_eidx; r_skip <= n_skip; r_f0 <= n_f0; r_f1 <= n_f1; r_ids <= n_ids;
        end
    end
endmodule

>>> rtl/core/dse_queue.sv
// Two-entry record queue between the parser and the output port.
module dse_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  dse_pkg::t_record  i_rec,
    output logic              o_has_room,
    output logic              o_valid,
    input  logic              i_ready,
    output dse_pkg::t_record  o_rec
);
    import dse_pkg::*;

    t_record     r_mem [QDEPTH];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        pop;

    assign pop = o_valid && i_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign o_has_room = (r_cnt != 2'(QDEPTH));
    assign o_rec = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_rec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, pop};
        end
    end
endmodule

>>> rtl/core/dvb_sdt_eit_section_parser_core.sv
// Top level of the DVB SDT/EIT section parser.
// Takes one section byte per cycle and gives at most one record per byte: an entry
// record as soon as an entry's fixed header is complete, and a status record on the
// byte marked buffer_end. The parser is combinational and pushes into a two-entry
// record queue; input is taken whenever the queue has room, so the rate is one
// byte per cycle while the output side keeps up. Entry records are tentative:
// keep them only if the following status record reads ok.
module dvb_sdt_eit_section_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_section_byte,
    input  logic        i_buffer_end,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_record_kind,
    output logic [15:0] o_entry_id,
    output logic        o_schedule_flag,
    output logic        o_present_following_flag,
    output logic [2:0]  o_run_status,
    output logic        o_free_ca,
    output logic [39:0] o_start_time_raw,
    output logic [23:0] o_duration_raw,
    output logic [15:0] o_ts_id,
    output logic [15:0] o_orig_net_id,
    output logic [2:0]  o_section_status
);
    import dse_pkg::*;

    logic [7:0] r_sdt_actual, r_sdt_other;
    logic       take, emit, room;
    t_record    rec, qrec;

    // Configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sdt_actual <= 8'd66;
            r_sdt_other  <= 8'd70;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SDT_ACTUAL: r_sdt_actual <= i_cfg_data;
                REG_SDT_OTHER:  r_sdt_other  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_ready = room;
    assign take = i_valid && room;

    dse_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(take),
        .i_section_byte(i_section_byte), .i_buffer_end(i_buffer_end),
        .i_sdt_actual(r_sdt_actual), .i_sdt_other(r_sdt_other),
        .o_emit(emit), .o_rec(rec)
    );

    dse_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(emit), .i_rec(rec),
        .o_has_room(room), .o_valid(o_valid), .i_ready(i_ready), .o_rec(qrec)
    );

    assign o_record_kind            = qrec.record_kind;
    assign o_entry_id               = qrec.entry_id;
    assign o_schedule_flag          = qrec.schedule_flag;
    assign o_present_following_flag = qrec.present_following_flag;
    assign o_run_status             = qrec.run_status;
    assign o_free_ca                = qrec.free_ca;
    assign o_start_time_raw         = qrec.start_time_raw;
    assign o_duration_raw           = qrec.duration_raw;
    assign o_ts_id                  = qrec.ts_id;
    assign o_orig_net_id            = qrec.orig_net_id;
    assign o_section_status         = qrec.section_status;
endmodule

>>> sim/testbench.sv
// Self-checking testbench for the DVB SDT/EIT section parser core.
`timescale 1ns / 1ps

module testbench;
    import dse_pkg::*;

    localparam int LIMIT_CYCLES = 600000;
    localparam int DRAIN_CYCLES = 20;

    // section build modes
    localparam int SEC_CLEAN   = 0;
    localparam int SEC_CORRUPT = 1;
    localparam int SEC_TRUNC   = 2;
    localparam int SEC_TRAIL   = 3;
    localparam int SEC_BAD_DLL = 4;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_byte_item;

    typedef enum logic [3:0] {
        W_HEADER  = 4'b0001,
        W_ENTRY   = 4'b0010,
        W_SKIP    = 4'b0100,
        W_STOPPED = 4'b1000
    } t_walk;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_section_byte;
    logic        i_buffer_end;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_record_kind;
    logic [15:0] o_entry_id;
    logic        o_schedule_flag;
    logic        o_present_following_flag;
    logic [2:0]  o_run_status;
    logic        o_free_ca;
    logic [39:0] o_start_time_raw;
    logic [23:0] o_duration_raw;
    logic [15:0] o_ts_id;
    logic [15:0] o_orig_net_id;
    logic [2:0]  o_section_status;

    dvb_sdt_eit_section_parser_core dut (.*);

    // stimulus and expectation stores
    t_byte_item  byte_feed[$];
    t_record     expected_records[$];
    int          mismatches = 0;
    int          cycles = 0;
    int          bytes_sent = 0;
    int          records_seen = 0;
    int          status_seen[5];
    bit          hold_feed = 0;
    bit          quiet = 0;

    // table id shadows
    logic [7:0]  cfg_actual_tid;
    logic [7:0]  cfg_other_tid;

    // predictor state of the section walk
    int unsigned sec_pos;
    logic [7:0]  sec_tid;
    logic [11:0] sec_len;
    logic [31:0] sec_crc;
    t_walk       sec_walk;
    int unsigned ent_idx;
    logic [11:0] skip_left;
    logic [63:0] ent_hi;
    logic [31:0] ent_lo;
    logic [15:0] hdr_tsid, hdr_onid, hdr_sid;

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [1:0] table_kind_of(input logic [7:0] tid);
        if (tid == cfg_actual_tid || tid == cfg_other_tid) return KIND_SDT;
        if (tid >= 8'h4E && tid <= 8'h6F) return KIND_EIT;
        return KIND_NONE;
    endfunction

    function automatic logic [31:0] crc32_mpeg_step(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {b, 24'd0};
        for (int i = 0; i < 8; i++)
            c = c[31] ? ((c << 1) ^ 32'h04C1_1DB7) : (c << 1);
        return c;
    endfunction

    task automatic clear_section();
        sec_pos = 0; sec_tid = '0; sec_len = '0; sec_crc = '1;
        sec_walk = W_HEADER; ent_idx = 0; skip_left = '0;
        ent_hi = '0; ent_lo = '0;
        hdr_tsid = '0; hdr_onid = '0; hdr_sid = '0;
    endtask

    // Walk one accepted byte and queue the record it causes, if any
    task automatic parse_section_byte(input logic [7:0] b, input logic last);
        int unsigned pos, total, hdr, lstart, dll, count;
        logic [1:0]  k;
        logic [7:0]  b2, b3;
        t_record     rec;
        bit          emit;
        rec = '0;
        emit = 0;
        k = KIND_NONE;
        pos = sec_pos;
        total = 3 + sec_len;
        if (pos < 3 || pos < total) begin
            sec_crc = crc32_mpeg_step(sec_crc, b);
            if (pos == 0) sec_tid = b;
            else if (pos == 1) sec_len = {b[3:0], 8'd0};
            else if (pos == 2) sec_len[7:0] = b;
            total = 3 + sec_len;
            k = table_kind_of(sec_tid);
            // header ids, high byte first
            if (k == KIND_SDT) begin
                if (pos == 3) hdr_tsid[15:8] = b;
                if (pos == 4) hdr_tsid[7:0] = b;
                if (pos == 8) hdr_onid[15:8] = b;
                if (pos == 9) hdr_onid[7:0] = b;
            end else if (k == KIND_EIT) begin
                if (pos == 3) hdr_sid[15:8] = b;
                if (pos == 4) hdr_sid[7:0] = b;
                if (pos == 8) hdr_tsid[15:8] = b;
                if (pos == 9) hdr_tsid[7:0] = b;
                if (pos == 10) hdr_onid[15:8] = b;
                if (pos == 11) hdr_onid[7:0] = b;
            end
            lstart = (k == KIND_SDT) ? 11 : 14;
            hdr = (k == KIND_SDT) ? 5 : 12;
            if (sec_walk == W_HEADER && k != KIND_NONE && pos == lstart) begin
                sec_walk = W_ENTRY;
                ent_idx = 0;
            end
            if (sec_walk == W_SKIP) begin
                skip_left = skip_left - 12'd1;
                if (skip_left == 12'd0) begin
                    sec_walk = W_ENTRY;
                    ent_idx = 0;
                end
            end else if (sec_walk == W_ENTRY && k != KIND_NONE) begin
                if (ent_idx == 0 && pos + hdr + 4 > total) begin
                    sec_walk = W_STOPPED;
                end else begin
                    if (ent_idx == 0) begin
                        ent_hi = '0;
                        ent_lo = '0;
                    end
                    if (ent_idx < 8) ent_hi = {ent_hi[55:0], b};
                    else ent_lo = {ent_lo[23:0], b};
                    ent_idx++;
                    if (ent_idx >= hdr) begin
                        if (k == KIND_SDT) begin
                            b2 = ent_hi[23:16];
                            b3 = ent_hi[15:8];
                            dll = 32'({b3[3:0], ent_hi[7:0]});
                            rec.record_kind = KIND_SDT;
                            rec.entry_id = ent_hi[39:24];
                            rec.schedule_flag = b2[1];
                            rec.present_following_flag = b2[0];
                            rec.run_status = b3[7:5];
                            rec.free_ca = b3[4];
                        end else begin
                            dll = 32'(ent_lo[11:0]);
                            rec.record_kind = KIND_EIT;
                            rec.entry_id = ent_hi[63:48];
                            rec.start_time_raw = ent_hi[47:8];
                            rec.duration_raw = {ent_hi[7:0], ent_lo[31:16]};
                        end
                        rec.ts_id = hdr_tsid;
                        rec.orig_net_id = hdr_onid;
                        ent_idx = 0;
                        if (pos + 1 + dll + 4 > total) begin
                            sec_walk = W_STOPPED;
                        end else begin
                            emit = 1;
                            if (dll > 0) begin
                                sec_walk = W_SKIP;
                                skip_left = 12'(dll);
                            end
                        end
                    end
                end
            end
        end
        if (sec_pos < 8191) sec_pos++;

        if (last) begin
            count = pos + 1;
            k = table_kind_of(sec_tid);
            total = 3 + sec_len;
            rec = '0;
            rec.record_kind = KIND_STATUS;
            if (count < 12) rec.section_status = ST_SHORT;
            else if (total > count) rec.section_status = ST_OVERRUN;
            else if (sec_crc != 0) rec.section_status = ST_CRC_FAIL;
            else if (k == KIND_NONE) rec.section_status = ST_WRONG_TBL;
            else rec.section_status = ST_OK;
            rec.entry_id = (k == KIND_EIT) ? hdr_sid : 16'd0;
            rec.present_following_flag = (k == KIND_EIT && sec_tid <= 8'h4F);
            rec.ts_id = hdr_tsid;
            rec.orig_net_id = hdr_onid;
            status_seen[rec.section_status]++;
            expected_records = {expected_records, rec};
            clear_section();
        end else if (emit) begin
            expected_records = {expected_records, rec};
        end
    endtask

    // Driver: one byte item per handshake, random gaps
    int gap_left = 0;
    always @(posedge i_clk) begin
        t_byte_item it;
        logic       nv;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_section_byte <= '0;
            i_buffer_end <= 1'b0;
            gap_left = 0;
        end else begin
            if (i_valid && o_ready) begin
                parse_section_byte(i_section_byte, i_buffer_end);
                bytes_sent++;
            end
            if (!i_valid || o_ready) begin
                nv = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (byte_feed.size() > 0 && !hold_feed) begin
                    it = byte_feed.pop_front();
                    nv = 1'b1;
                    i_section_byte <= it.data;
                    i_buffer_end <= it.last;
                    if (!quiet && $urandom_range(0, 7) == 0)
                        gap_left = $urandom_range(1, 4);
                end
                i_valid <= nv;
            end
        end
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        mismatches++;
        $display("mismatch %s: got 0x%0h, expected 0x%0h (cycle %0d)", what, got, want, cycles);
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) report(what, got, want);
    endtask

    // Monitor: compare each record with the oldest expectation, random stalls
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_record want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_valid && i_ready) begin
                records_seen++;
                if (expected_records.size() == 0) begin
                    report("unexpected record kind", 64'(o_record_kind), 64'(0));
                end else begin
                    want = expected_records.pop_front();
                    check_field("record_kind", 64'(o_record_kind), 64'(want.record_kind));
                    check_field("entry_id", 64'(o_entry_id), 64'(want.entry_id));
                    check_field("schedule_flag", 64'(o_schedule_flag),
                                64'(want.schedule_flag));
                    check_field("present_following_flag", 64'(o_present_following_flag),
                                64'(want.present_following_flag));
                    check_field("run_status", 64'(o_run_status), 64'(want.run_status));
                    check_field("free_ca", 64'(o_free_ca), 64'(want.free_ca));
                    check_field("start_time_raw", 64'(o_start_time_raw),
                                64'(want.start_time_raw));
                    check_field("duration_raw", 64'(o_duration_raw), 64'(want.duration_raw));
                    check_field("ts_id", 64'(o_ts_id), 64'(want.ts_id));
                    check_field("orig_net_id", 64'(o_orig_net_id), 64'(want.orig_net_id));
                    check_field("section_status", 64'(o_section_status),
                                64'(want.section_status));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 3);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    task automatic queue_buffer(input logic [7:0] s[$]);
        t_byte_item it;
        foreach (s[i]) begin
            it.data = s[i];
            it.last = (i == s.size() - 1);
            byte_feed = {byte_feed, it};
        end
    endtask

    // Build one section in the given mode: clean, one corrupt byte, truncated,
    // trailing bytes, or a descriptor length running past the CRC
    task automatic add_section(input logic [7:0] tid, input int n_ent, input int max_dll,
                               input int mode);
        logic [7:0]  s[$];
        logic [31:0] c;
        logic [11:0] len, dll, dll_field;
        bit          eit;
        int          nhdr, cut;
        eit = (table_kind_of(tid) == KIND_EIT) ||
              (table_kind_of(tid) == KIND_NONE && $urandom_range(0, 1));
        s = {tid, 8'd0, 8'd0};
        nhdr = eit ? 11 : 8;
        repeat (nhdr) s = {s, 8'($urandom)};
        for (int e = 0; e < n_ent; e++) begin
            dll = 12'($urandom_range(0, max_dll));
            dll_field = (mode == SEC_BAD_DLL && e == 0) ?
                        12'($urandom_range(200, 4095)) : dll;
            repeat (eit ? 10 : 3) s = {s, 8'($urandom)};
            s = {s, {4'($urandom), dll_field[11:8]}};
            s = {s, dll_field[7:0]};
            repeat (dll) s = {s, 8'($urandom)};
        end
        len = 12'(s.size() + 1);
        s[1] = {4'($urandom), len[11:8]};
        s[2] = len[7:0];
        c = '1;
        foreach (s[i]) c = crc32_mpeg_step(c, s[i]);
        for (int i = 3; i >= 0; i--) s = {s, c[8*i +: 8]};
        if (mode == SEC_CORRUPT) begin
            cut = $urandom_range(0, s.size() - 1);
            s[cut] = s[cut] ^ (8'd1 << $urandom_range(0, 7));
        end else if (mode == SEC_TRUNC) begin
            cut = $urandom_range(1, s.size() - 1);
            while (s.size() > cut) void'(s.pop_back());
        end else if (mode == SEC_TRAIL) begin
            repeat ($urandom_range(1, 6)) s = {s, 8'($urandom)};
        end
        queue_buffer(s);
    endtask

    task automatic add_garbage(input int n);
        logic [7:0] s[$];
        repeat (n) s = {s, 8'($urandom)};
        queue_buffer(s);
    endtask

    function automatic logic [7:0] pick_table_id();
        case ($urandom_range(0, 9))
            0, 1: return cfg_actual_tid;
            2, 3: return cfg_other_tid;
            4: return 8'h4E;
            5: return 8'h4F;
            6, 7: return 8'($urandom_range(8'h50, 8'h6F));
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic add_random_buffers(input int n_bytes);
        int target, pick;
        target = byte_feed.size() + n_bytes;
        while (byte_feed.size() < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
                add_section(pick_table_id(), $urandom_range(0, 4), 4, SEC_CLEAN);
            else if (pick < 73)
                add_section(pick_table_id(), $urandom_range(0, 3), 3, SEC_CORRUPT);
            else if (pick < 81)
                add_section(pick_table_id(), $urandom_range(0, 3), 3, SEC_TRUNC);
            else if (pick < 88)
                add_section(pick_table_id(), $urandom_range(0, 3), 3, SEC_TRAIL);
            else if (pick < 94)
                add_section(pick_table_id(), $urandom_range(1, 3), 3, SEC_BAD_DLL);
            else
                add_garbage($urandom_range(1, 30));
        end
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (byte_feed.size() > 0 || i_valid || expected_records.size() > 0);
    endtask

    task automatic write_table_id(input logic [0:0] idx, input logic [7:0] value);
        wait_drained();
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        if (idx == REG_SDT_ACTUAL) cfg_actual_tid = value;
        else cfg_other_tid = value;
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        i_rst_n = 0;
        i_cfg_valid = 0;
        i_cfg_index = REG_SDT_ACTUAL;
        i_cfg_data = '0;
        cfg_actual_tid = 8'd66;
        cfg_other_tid = 8'd70;
        foreach (status_seen[i]) status_seen[i] = 0;
        clear_section();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: every status, both kinds, loop stops, trailing bytes
        add_section(8'd66, 2, 3, SEC_CLEAN);
        add_section(8'd70, 1, 0, SEC_CLEAN);
        add_section(8'h4E, 2, 2, SEC_CLEAN);
        add_section(8'h6F, 1, 0, SEC_CLEAN);
        add_section(8'h00, 1, 1, SEC_CLEAN);
        add_section(8'hFF, 0, 0, SEC_CLEAN);
        add_section(8'd66, 1, 2, SEC_CORRUPT);
        add_section(8'h50, 2, 1, SEC_TRUNC);
        add_garbage(5);
        add_garbage(1);
        add_section(8'd66, 2, 1, SEC_TRAIL);
        add_section(8'h4F, 2, 2, SEC_BAD_DLL);
        add_section(8'd66, 0, 0, SEC_CLEAN);
        add_random_buffers(60);

        // pause the sender until every record is back
        while (byte_feed.size() > 60) @(posedge i_clk);
        hold_feed = 1;
        while (i_valid || expected_records.size() > 0) @(posedge i_clk);
        hold_feed = 0;

        // table id extremes
        write_table_id(REG_SDT_ACTUAL, 8'h00);
        write_table_id(REG_SDT_OTHER, 8'hFF);
        add_section(8'h00, 2, 2, SEC_CLEAN);
        add_section(8'hFF, 2, 2, SEC_CLEAN);
        add_section(8'd66, 1, 1, SEC_CLEAN);
        add_random_buffers(60);

        // SDT ids overlapping the EIT range take precedence
        write_table_id(REG_SDT_ACTUAL, 8'h4E);
        write_table_id(REG_SDT_OTHER, 8'h6F);
        add_section(8'h4E, 2, 2, SEC_CLEAN);
        add_section(8'h6F, 1, 1, SEC_CLEAN);
        add_random_buffers(60);

        // random table id settings
        write_table_id(REG_SDT_ACTUAL, 8'($urandom));
        write_table_id(REG_SDT_OTHER, 8'($urandom));
        add_random_buffers(60);

        // back to defaults, last part without idling
        write_table_id(REG_SDT_ACTUAL, 8'd66);
        write_table_id(REG_SDT_OTHER, 8'd70);
        add_random_buffers(30);
        wait_drained();
        quiet = 1;
        repeat (5) @(posedge i_clk);
        add_random_buffers(30);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("sent %0d section bytes, checked %0d records", bytes_sent, records_seen);
        $display("status ok %0d, short %0d, overrun %0d, crc fail %0d, wrong table %0d",
                 status_seen[ST_OK], status_seen[ST_SHORT], status_seen[ST_OVERRUN],
                 status_seen[ST_CRC_FAIL], status_seen[ST_WRONG_TBL]);
        if (mismatches == 0 && expected_records.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d records missing", mismatches,
                     expected_records.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> dvb_sdt_eit_section_parser_core.f
rtl/core/dse_pkg.sv
rtl/core/dse_front.sv
rtl/core/dse_queue.sv
rtl/core/dvb_sdt_eit_section_parser_core.sv
sim/testbench.sv
